### src/gdet_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the grid dot edge tracer.
package gdet_pkg;

    localparam int GRID      = 5;
    localparam int NCELL     = GRID * GRID;
    localparam int NHORIZ    = GRID * (GRID - 1);
    localparam int NEDGE     = 2 * GRID * (GRID - 1);
    localparam int CRD_W     = $clog2(GRID);
    localparam int CELL_W    = $clog2(NCELL);
    localparam int EDGE_W    = $clog2(NEDGE);
    localparam int SP_W      = $clog2(NEDGE + 2);
    localparam int ST_AW     = $clog2(NEDGE);
    localparam int DOT_W     = 10;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int POS_W     = 13;
    localparam int PACK_W    = 2 * POS_W;

    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] CELL_WIDTH_RST  = 10'd128;
    localparam logic [CFG_W-1:0] CELL_HEIGHT_RST = 10'd96;

    typedef enum logic [1:0] {
        DIR_TOP    = 2'd0,
        DIR_RIGHT  = 2'd1,
        DIR_BOTTOM = 2'd2,
        DIR_LEFT   = 2'd3
    } dir_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_POP,
        ST_EMIT,
        ST_FINISH,
        ST_CLEAR
    } walk_state_t;

    typedef struct packed {
        logic [CRD_W-1:0] cx;
        logic [CRD_W-1:0] cy;
        dir_t             dir;
    } stack_entry_t;

    typedef struct packed {
        logic              ok;
        logic [CRD_W-1:0]  nbx;
        logic [CRD_W-1:0]  nby;
        logic [CELL_W-1:0] nb_cell;
        logic [EDGE_W-1:0] eidx;
    } step_t;

    typedef struct packed {
        logic             found;
        logic [CRD_W-1:0] cx;
        logic [CRD_W-1:0] cy;
    } start_t;

    typedef struct packed {
        logic [CELL_W-1:0] addr_a;
        logic [CELL_W-1:0] addr_b;
    } pos_rd_t;

    typedef struct packed {
        logic [POS_W-1:0] start_x;
        logic [POS_W-1:0] start_y;
        logic [POS_W-1:0] end_x;
        logic [POS_W-1:0] end_y;
        logic             segment_valid;
        logic             last_segment;
    } seg_t;

    function automatic logic [CELL_W-1:0] cell_of(logic [CRD_W-1:0] cx,
                                                  logic [CRD_W-1:0] cy);
        int c;
        c = int'(cx) * GRID + int'(cy);
        return CELL_W'(c);
    endfunction

    // Neighbor and edge index one step from (cx, cy) toward d.
    function automatic step_t edge_step(stack_entry_t t);
        step_t s;
        int    e;
        s.ok  = 1'b0;
        s.nbx = t.cx;
        s.nby = t.cy;
        e     = 0;
        case (t.dir)
            DIR_TOP:
            begin
                if (t.cy != '0)
                begin
                    s.ok  = 1'b1;
                    s.nby = t.cy - CRD_W'(1);
                    e     = NHORIZ + int'(t.cx) * (GRID - 1) + int'(t.cy) - 1;
                end
            end
            DIR_RIGHT:
            begin
                if (t.cx < CRD_W'(GRID - 1))
                begin
                    s.ok  = 1'b1;
                    s.nbx = t.cx + CRD_W'(1);
                    e     = int'(t.cy) * (GRID - 1) + int'(t.cx);
                end
            end
            DIR_BOTTOM:
            begin
                if (t.cy < CRD_W'(GRID - 1))
                begin
                    s.ok  = 1'b1;
                    s.nby = t.cy + CRD_W'(1);
                    e     = NHORIZ + int'(t.cx) * (GRID - 1) + int'(t.cy);
                end
            end
            default:
            begin
                if (t.cx != '0)
                begin
                    s.ok  = 1'b1;
                    s.nbx = t.cx - CRD_W'(1);
                    e     = int'(t.cy) * (GRID - 1) + int'(t.cx) - 1;
                end
            end
        endcase
        s.nb_cell = cell_of(s.nbx, s.nby);
        s.eidx    = EDGE_W'(e);
        return s;
    endfunction

    // Bottom row first, right column first within a row.
    function automatic start_t find_start(logic [NCELL-1:0] occ);
        start_t r;
        r = '0;
        for (int y = 0; y < GRID; y++)
        begin
            for (int x = 0; x < GRID; x++)
            begin
                if (occ[x * GRID + y])
                begin
                    r.found = 1'b1;
                    r.cx    = CRD_W'(x);
                    r.cy    = CRD_W'(y);
                end
            end
        end
        return r;
    endfunction

endpackage

### src/gdet_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module gdet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/gdet_walker.sv
`timescale 1ns / 1ps
// Depth-first edge walk over the loaded grid with a RAM-backed stack.
module gdet_walker
    import gdet_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NCELL-1:0]  occ,
    input  logic [PACK_W-1:0] pos_a,
    input  logic [PACK_W-1:0] pos_b,
    input  logic              out_ready,
    output pos_rd_t           rd,
    output logic              busy,
    output logic              out_valid,
    output seg_t              seg
);

    walk_state_t  state_reg, state_next;
    stack_entry_t top_reg, top_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [EDGE_W-1:0] clr_reg, clr_next;
    seg_t         pend_reg, pend_next;
    logic         pend_valid_reg, pend_valid_next;
    seg_t         out_reg, out_next;
    logic         out_valid_reg, out_valid_next;

    logic             st_we;
    logic [ST_AW-1:0] st_waddr;
    logic [ST_AW-1:0] st_raddr;
    stack_entry_t     st_wdata;
    stack_entry_t     st_rdata;

    logic              eu_we;
    logic [EDGE_W-1:0] eu_waddr;
    logic              eu_wdata;
    logic [EDGE_W-1:0] eu_raddr;
    logic              eu_rdata;

    step_t  step;
    step_t  step_ahead;
    start_t start_hit;
    logic   take;
    logic   last_dir;
    logic   slot_free;

    gdet_ram #(
        .WIDTH($bits(stack_entry_t)),
        .DEPTH(NEDGE)
    ) u_stack (
        .clk  (clk),
        .we   (st_we),
        .waddr(st_waddr),
        .wdata(st_wdata),
        .raddr(st_raddr),
        .rdata(st_rdata)
    );

    // Used-edge flags, cleared by a pass over every entry after each grid.
    gdet_ram #(
        .WIDTH(1),
        .DEPTH(NEDGE)
    ) u_edge_used (
        .clk  (clk),
        .we   (eu_we),
        .waddr(eu_waddr),
        .wdata(eu_wdata),
        .raddr(eu_raddr),
        .rdata(eu_rdata)
    );

    assign step       = edge_step(top_reg);
    assign start_hit  = find_start(occ);
    assign take       = step.ok && occ[step.nb_cell] && !eu_rdata;
    assign last_dir   = (top_reg.dir == DIR_LEFT);
    assign slot_free  = !out_valid_reg || out_ready;

    // Fetch the flag of the edge that the next cycle's top will try.
    assign step_ahead = edge_step(top_next);
    assign eu_raddr   = step_ahead.eidx;

    // Entry below the top sits at sp - 2; the top itself lives in top_reg.
    assign st_raddr  = ST_AW'(sp_reg - SP_W'(2));
    assign st_waddr  = ST_AW'(sp_reg - SP_W'(1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = start_hit.found ? ST_WALK : ST_FINISH;
            end
            ST_WALK:
            begin
                if (take)
                begin
                    if (slot_free)
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else if (last_dir)
                begin
                    state_next = (sp_reg == SP_W'(1)) ? ST_FINISH : ST_POP;
                end
            end
            ST_POP:
            begin
                state_next = ST_WALK;
            end
            ST_EMIT:
            begin
                state_next = ST_WALK;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                if (clr_reg == EDGE_W'(NEDGE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        top_next        = top_reg;
        sp_next         = sp_reg;
        clr_next        = clr_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        st_we           = 1'b0;
        st_wdata        = top_reg;
        eu_we           = 1'b0;
        eu_waddr        = step.eidx;
        eu_wdata        = 1'b1;
        rd.addr_a       = cell_of(top_reg.cx, top_reg.cy);
        rd.addr_b       = step.nb_cell;
        case (state_reg)
            ST_START:
            begin
                if (start_hit.found)
                begin
                    top_next.cx  = start_hit.cx;
                    top_next.cy  = start_hit.cy;
                    top_next.dir = DIR_TOP;
                    sp_next      = SP_W'(1);
                end
            end
            ST_WALK:
            begin
                if (take)
                begin
                    if (slot_free)
                    begin
                        eu_we        = 1'b1;
                        top_next.cx  = step.nbx;
                        top_next.cy  = step.nby;
                        top_next.dir = DIR_TOP;
                        // Keep the current cell below the new top unless it is spent.
                        if (!last_dir)
                        begin
                            st_we        = 1'b1;
                            st_wdata.dir = dir_t'(2'(top_reg.dir) + 2'd1);
                            sp_next      = sp_reg + SP_W'(1);
                        end
                    end
                end
                else if (last_dir)
                begin
                    sp_next = sp_reg - SP_W'(1);
                end
                else
                begin
                    top_next.dir = dir_t'(2'(top_reg.dir) + 2'd1);
                end
            end
            ST_POP:
            begin
                top_next = st_rdata;
            end
            ST_EMIT:
            begin
                // Hold one segment back so the final one can carry the last flag.
                if (pend_valid_reg)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                end
                pend_next.start_x       = pos_a[POS_W-1:0];
                pend_next.start_y       = pos_a[PACK_W-1:POS_W];
                pend_next.end_x         = pos_b[POS_W-1:0];
                pend_next.end_y         = pos_b[PACK_W-1:POS_W];
                pend_next.segment_valid = 1'b1;
                pend_next.last_segment  = 1'b0;
                pend_valid_next         = 1'b1;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_next = pend_reg;
                    end
                    else
                    begin
                        out_next = '0;
                    end
                    out_next.last_segment = 1'b1;
                    out_valid_next        = 1'b1;
                    pend_valid_next       = 1'b0;
                    sp_next               = '0;
                    clr_next              = '0;
                end
            end
            ST_CLEAR:
            begin
                eu_we    = 1'b1;
                eu_waddr = clr_reg;
                eu_wdata = 1'b0;
                clr_next = clr_reg + EDGE_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            sp_reg         <= '0;
            clr_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sp_reg         <= sp_next;
            clr_reg        <= clr_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign seg       = out_reg;

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(NEDGE + 1))
        else $error("walk stack pointer beyond capacity");

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> !out_valid_reg)
        else $error("output register busy when a segment moves out");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> (!pend_valid_reg && sp_reg == '0))
        else $error("walk state left over after a grid");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> (!pend_valid_reg && sp_reg == '0))
        else $error("walk still active during the flag clearing pass");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && out_reg.last_segment |-> state_reg == ST_CLEAR)
        else $error("last beat issued while the walk is still running");

endmodule

### src/grid_dot_edge_tracer.sv
`timescale 1ns / 1ps
// Top level: configuration, cell loading into position RAM, and the edge walker.
//
// Usage:
//   Dots enter on the in channel (in_valid/in_ready, dot_x/dot_y), one per
//   grid cell, column by column, GRID*GRID beats per grid. A loading beat is
//   taken every cycle while in_ready is high; no result comes out for it.
//   After the last beat of a grid the walker runs. It tries the directions
//   of the top cell in turn, with an extra step per emitted edge (position
//   RAM read) and per pop (stack RAM read), plus one start and one finish
//   step. The used-edge flags are then cleared over all NEDGE (40) entries;
//   in_ready stays low from the walk start until that pass is done.
//   Results leave on the out channel (out_valid/out_ready): one beat per
//   segment, or one empty marker beat with segment_valid low. last_segment
//   marks the final beat of a grid. One segment is held back so the last
//   flag is known, so a segment appears after the next is found or the walk
//   ends. A stalled receiver stops the walk at the next found edge; nothing
//   drops. cfg_write/cfg_index/cfg_data set cell_width and cell_height, to be
//   written while the block is idle. Reset restores 128 and 96, runs the
//   flag clearing pass with in_ready low, then takes a fresh grid.
module grid_dot_edge_tracer
    import gdet_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [DOT_W-1:0]     dot_x,
    input  logic [DOT_W-1:0]     dot_y,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [POS_W-1:0]     start_x,
    output logic [POS_W-1:0]     start_y,
    output logic [POS_W-1:0]     end_x,
    output logic [POS_W-1:0]     end_y,
    output logic                 segment_valid,
    output logic                 last_segment
);

    logic [CFG_W-1:0]  cell_width_reg, cell_width_next;
    logic [CFG_W-1:0]  cell_height_reg, cell_height_next;
    logic [CRD_W-1:0]  load_cx_reg, load_cx_next;
    logic [CRD_W-1:0]  load_cy_reg, load_cy_next;
    logic [NCELL-1:0]  occ_reg, occ_next;

    logic              load;
    logic              grid_done;
    logic [CELL_W-1:0] load_cell;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [PACK_W-1:0] pos_w;
    logic [PACK_W-1:0] pos_a;
    logic [PACK_W-1:0] pos_b;
    pos_rd_t           rd;
    logic              busy;
    seg_t              seg;

    assign load      = in_valid && in_ready;
    assign in_ready  = !busy;
    assign load_cell = cell_of(load_cx_reg, load_cy_reg);
    assign grid_done = load && (load_cx_reg == CRD_W'(GRID - 1))
                            && (load_cy_reg == CRD_W'(GRID - 1));

    assign pos_x = POS_W'(dot_x) + POS_W'(cell_width_reg) * POS_W'(load_cx_reg);
    assign pos_y = POS_W'(dot_y) + POS_W'(cell_height_reg) * POS_W'(load_cy_reg);
    assign pos_w = {pos_y, pos_x};

    always_comb
    begin
        cell_width_next  = cell_width_reg;
        cell_height_next = cell_height_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_CELL_WIDTH:  cell_width_next  = cfg_data;
                REG_CELL_HEIGHT: cell_height_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        load_cx_next = load_cx_reg;
        load_cy_next = load_cy_reg;
        occ_next     = occ_reg;
        if (load)
        begin
            occ_next[load_cell] = (dot_x != '0) && (dot_y != '0);
            // Advance down the column, then to the next column; wrap at the grid end.
            if (load_cy_reg == CRD_W'(GRID - 1))
            begin
                load_cy_next = '0;
                if (load_cx_reg == CRD_W'(GRID - 1))
                begin
                    load_cx_next = '0;
                end
                else
                begin
                    load_cx_next = load_cx_reg + CRD_W'(1);
                end
            end
            else
            begin
                load_cy_next = load_cy_reg + CRD_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_width_reg  <= CELL_WIDTH_RST;
            cell_height_reg <= CELL_HEIGHT_RST;
            load_cx_reg     <= '0;
            load_cy_reg     <= '0;
            occ_reg         <= '0;
        end
        else
        begin
            cell_width_reg  <= cell_width_next;
            cell_height_reg <= cell_height_next;
            load_cx_reg     <= load_cx_next;
            load_cy_reg     <= load_cy_next;
            occ_reg         <= occ_next;
        end
    end

    // Two copies of the position store give both segment ends in one read.
    gdet_ram #(
        .WIDTH(PACK_W),
        .DEPTH(NCELL)
    ) u_pos_a (
        .clk  (clk),
        .we   (load),
        .waddr(load_cell),
        .wdata(pos_w),
        .raddr(rd.addr_a),
        .rdata(pos_a)
    );

    gdet_ram #(
        .WIDTH(PACK_W),
        .DEPTH(NCELL)
    ) u_pos_b (
        .clk  (clk),
        .we   (load),
        .waddr(load_cell),
        .wdata(pos_w),
        .raddr(rd.addr_b),
        .rdata(pos_b)
    );

    gdet_walker u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (grid_done),
        .occ      (occ_reg),
        .pos_a    (pos_a),
        .pos_b    (pos_b),
        .out_ready(out_ready),
        .rd       (rd),
        .busy     (busy),
        .out_valid(out_valid),
        .seg      (seg)
    );

    assign start_x       = seg.start_x;
    assign start_y       = seg.start_y;
    assign end_x         = seg.end_x;
    assign end_y         = seg.end_y;
    assign segment_valid = seg.segment_valid;
    assign last_segment  = seg.last_segment;

endmodule
